// ----- hdl/qti_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qti_pkg: shared types and constants of the quad table interpolator
// Opcodes, word kinds, register indexes, queue word layout, status groups.
// ----------------------------------------------------------------------------
package qti_pkg;

    // input opcodes
    localparam logic [1:0] OP_BPW    = 2'd0;
    localparam logic [1:0] OP_ENT    = 2'd1;
    localparam logic [1:0] OP_QRY    = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;   // ignored, gives no result

    // configuration register indexes
    localparam logic [1:0] REG_ALPHA = 2'd0;
    localparam logic [1:0] REG_SPEED = 2'd1;
    localparam logic [1:0] REG_FREQ  = 2'd2;
    localparam logic [1:0] REG_PHASE = 2'd3;

    // axis geometry
    localparam int AXES      = 4;
    localparam int PTS_LIMIT = 8;   // breakpoints usable per axis
    localparam int QDEPTH    = 2;   // front to back queue depth

    // stream word widths
    localparam int S_TDATA_W = 312;
    localparam int M_TDATA_W = 128;

    typedef enum logic [1:0] {
        K_NOP,
        K_BP,
        K_ENT,
        K_QRY
    } t_kind;

    // one classified word in the queue
    typedef struct packed {
        t_kind               kind;
        logic [4:0]          slot;
        logic [11:0]         addr;
        logic [31:0]         bpval;
        logic [3:0][31:0]    quad;   // table entries or query coordinates
    } t_qitem;

    typedef struct packed {
        logic [1:0] count;
        logic       full;
    } t_fstat;

    typedef struct packed {
        logic busy;
        logic hunting;
    } t_bstat;

    typedef enum logic [4:0] {
        S_IDLE,
        S_AX_LO,
        S_AX_HI,
        S_AX_CL,
        S_DN_RD,
        S_DN_CK,
        S_UP_RD,
        S_UP_CK,
        S_X0_RD,
        S_X0_CK,
        S_DV_INIT,
        S_DV_STEP,
        S_CR_RD,
        S_CR_END,
        S_LP_A,
        S_LP_B,
        S_DONE
    } t_state;

endpackage

// ----- hdl/qti_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qti_front: input classifier and word queue
// Unpacks the input word, classifies it by opcode, drops unused opcodes and
// queues the rest for the back end.
// ----------------------------------------------------------------------------
module qti_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [1:0]                      i_opcode,
    input  logic [qti_pkg::S_TDATA_W-1:0]   i_data,
    output qti_pkg::t_qitem                 o_item,
    output logic                            o_item_valid,
    input  logic                            i_item_ready,
    output qti_pkg::t_fstat                 o_stat
);

    qti_pkg::t_qitem w_item;
    qti_pkg::t_qitem r_q [qti_pkg::QDEPTH];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;
    logic            w_push;
    logic            w_pop;

    // classify and unpack
    always_comb begin
        case (i_opcode)
            qti_pkg::OP_BPW: w_item.kind = qti_pkg::K_BP;
            qti_pkg::OP_ENT: w_item.kind = qti_pkg::K_ENT;
            qti_pkg::OP_QRY: w_item.kind = qti_pkg::K_QRY;
            default:         w_item.kind = qti_pkg::K_NOP;
        endcase
        w_item.slot  = i_data[4:0];
        w_item.addr  = i_data[16:5];
        w_item.bpval = i_data[48:17];
        if (w_item.kind == qti_pkg::K_QRY) begin
            w_item.quad = i_data[304:177];
        end else begin
            w_item.quad = i_data[176:49];
        end
    end

    assign o_ready      = (r_cnt != 2'(qti_pkg::QDEPTH));
    assign w_push       = i_valid && o_ready && (w_item.kind != qti_pkg::K_NOP);
    assign o_item_valid = (r_cnt != 2'd0);
    assign w_pop        = o_item_valid && i_item_ready;
    assign o_item       = r_q[r_rp];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_stat.count = r_cnt;
    assign o_stat.full  = !o_ready;

endmodule

// ----- hdl/qti_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qti_back: table store and interpolation engine
// Holds breakpoints and coefficient tables, hunts the bracketing intervals,
// computes weights with a bit-serial divider and reduces sixteen corners per
// table with one multiplier per table.
// ----------------------------------------------------------------------------
module qti_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  qti_pkg::t_qitem             i_item,
    input  logic                        i_item_valid,
    output logic                        o_item_ready,
    input  logic [3:0][3:0]             i_points,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [3:0][31:0]            o_vals,
    output logic                        o_deg,
    output qti_pkg::t_bstat             o_stat
);

    localparam int TW  = FRAC_BITS + 1;          // weight width
    localparam int PW  = 35 + FRAC_BITS;         // product width
    localparam int SW  = PW + 1;                 // sum width
    localparam int DCW = $clog2(FRAC_BITS + 1);

    qti_pkg::t_state r_state, n_state;

    // memories
    logic signed [31:0] m_bp  [32];
    logic [127:0]       m_tab [4096];
    logic signed [31:0] r_bp_q;
    logic [127:0]       r_tab_q;
    logic [4:0]         w_bp_ra;
    logic [11:0]        w_tab_ra;
    logic               w_bp_we;
    logic               w_tab_we;

    // query and hunt state
    logic signed [31:0] r_qx   [4];
    logic [1:0]         r_ax;
    logic [2:0]         r_i;
    logic signed [31:0] r_x;
    logic [2:0]         r_hint [4];
    logic [2:0]         r_idx  [4];
    logic signed [31:0] r_x0   [4];
    logic signed [31:0] r_x1   [4];
    logic signed [31:0] r_px   [4];
    logic               r_deg;

    // divider
    logic [33:0]        r_rem;
    logic [31:0]        r_den;
    logic [TW-1:0]      r_quo;
    logic [DCW-1:0]     r_dc;
    logic [TW-1:0]      r_t [4];

    // corner reduction
    logic [3:0]         r_m;
    logic               r_ld_v;
    logic [3:0]         r_ld_m;
    logic signed [31:0] r_vals [4][16];
    logic [4:0]         r_cnt;
    logic [3:0]         r_k;
    logic signed [31:0] r_y0   [4];
    logic signed [PW-1:0] r_prod [4];
    logic signed [31:0] w_res  [4];

    // output register
    logic               r_ov;
    logic [3:0][31:0]   r_oval;
    logic               r_odeg;

    // helpers
    logic [3:0]         w_pts;
    logic [3:0]         w_n;
    logic [2:0]         w_nm1;
    logic [2:0]         w_nm2;
    logic               w_dn_go;
    logic               w_up_go;
    logic signed [32:0] w_d;
    logic signed [32:0] w_off;
    logic               w_ge;
    logic [1:0]         w_lax;
    logic               w_out_free;

    // points in use on the current axis
    always_comb begin
        w_pts = i_points[r_ax];
        if (w_pts < 4'd2) begin
            w_n = 4'd2;
        end else if (w_pts > 4'(qti_pkg::PTS_LIMIT)) begin
            w_n = 4'(qti_pkg::PTS_LIMIT);
        end else begin
            w_n = w_pts;
        end
        w_nm1 = 3'(w_n - 4'd1);
        w_nm2 = 3'(w_n - 4'd2);
    end

    assign w_dn_go = (r_i != 3'd0) && (r_x < r_bp_q);
    assign w_up_go = (r_i < w_nm2) && (r_x > r_bp_q);
    assign w_d     = 33'(r_x1[r_ax]) - 33'(r_x0[r_ax]);
    assign w_off   = 33'(r_px[r_ax]) - 33'(r_x0[r_ax]);
    assign w_ge    = (r_rem >= {2'b00, r_den});
    assign w_out_free = !r_ov || i_ready;

    // axis of lerp k: phase first, then freq, speed, alpha
    always_comb begin
        if (r_k < 4'd8) begin
            w_lax = 2'd3;
        end else if (r_k < 4'd12) begin
            w_lax = 2'd2;
        end else if (r_k < 4'd14) begin
            w_lax = 2'd1;
        end else begin
            w_lax = 2'd0;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            qti_pkg::S_IDLE: begin
                if (i_item_valid && i_item.kind == qti_pkg::K_QRY) begin
                    n_state = qti_pkg::S_AX_LO;
                end
            end
            qti_pkg::S_AX_LO: n_state = qti_pkg::S_AX_HI;
            qti_pkg::S_AX_HI: n_state = qti_pkg::S_AX_CL;
            qti_pkg::S_AX_CL: n_state = qti_pkg::S_DN_RD;
            qti_pkg::S_DN_RD: n_state = qti_pkg::S_DN_CK;
            qti_pkg::S_DN_CK: begin
                n_state = w_dn_go ? qti_pkg::S_DN_RD : qti_pkg::S_UP_RD;
            end
            qti_pkg::S_UP_RD: n_state = qti_pkg::S_UP_CK;
            qti_pkg::S_UP_CK: begin
                n_state = w_up_go ? qti_pkg::S_UP_RD : qti_pkg::S_X0_RD;
            end
            qti_pkg::S_X0_RD: n_state = qti_pkg::S_X0_CK;
            qti_pkg::S_X0_CK: begin
                n_state = (r_ax == 2'd3) ? qti_pkg::S_DV_INIT : qti_pkg::S_AX_LO;
            end
            qti_pkg::S_DV_INIT: begin
                if (w_d > 33'sd0) begin
                    n_state = qti_pkg::S_DV_STEP;
                end else if (r_ax == 2'd3) begin
                    n_state = qti_pkg::S_CR_RD;
                end
            end
            qti_pkg::S_DV_STEP: begin
                if (r_dc == DCW'(FRAC_BITS)) begin
                    n_state = (r_ax == 2'd3) ? qti_pkg::S_CR_RD : qti_pkg::S_DV_INIT;
                end
            end
            qti_pkg::S_CR_RD: begin
                if (r_m == 4'd15) begin
                    n_state = qti_pkg::S_CR_END;
                end
            end
            qti_pkg::S_CR_END: n_state = qti_pkg::S_LP_A;
            qti_pkg::S_LP_A:   n_state = qti_pkg::S_LP_B;
            qti_pkg::S_LP_B: begin
                n_state = (r_k == 4'd14) ? qti_pkg::S_DONE : qti_pkg::S_LP_A;
            end
            qti_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = qti_pkg::S_IDLE;
                end
            end
            default: n_state = qti_pkg::S_IDLE;
        endcase
    end

    // state outputs: handshake, memory addresses, write enables
    always_comb begin
        o_item_ready = (r_state == qti_pkg::S_IDLE);
        w_bp_we      = (r_state == qti_pkg::S_IDLE) && i_item_valid
                       && (i_item.kind == qti_pkg::K_BP);
        w_tab_we     = (r_state == qti_pkg::S_IDLE) && i_item_valid
                       && (i_item.kind == qti_pkg::K_ENT);
        w_tab_ra     = {3'(r_idx[0] + {2'b00, r_m[3]}), 3'(r_idx[1] + {2'b00, r_m[2]}),
                        3'(r_idx[2] + {2'b00, r_m[1]}), 3'(r_idx[3] + {2'b00, r_m[0]})};
        case (r_state)
            qti_pkg::S_AX_LO: w_bp_ra = {r_ax, 3'd0};
            qti_pkg::S_AX_HI: w_bp_ra = {r_ax, w_nm1};
            qti_pkg::S_DN_RD: w_bp_ra = {r_ax, r_i};
            qti_pkg::S_UP_RD: w_bp_ra = {r_ax, 3'(r_i + 3'd1)};
            qti_pkg::S_X0_RD: w_bp_ra = {r_ax, r_i};
            default:          w_bp_ra = {r_ax, r_i};
        endcase
    end

    // breakpoint and table memories
    always_ff @(posedge i_clk) begin
        if (w_bp_we) begin
            m_bp[i_item.slot] <= i_item.bpval;
        end
        r_bp_q <= m_bp[w_bp_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_tab_we) begin
            m_tab[i_item.addr] <= i_item.quad;
        end
        r_tab_q <= m_tab[w_tab_ra];
    end

    // lerp result per table: y0 + round((y1 - y0) * t), saturated
    for (genvar tb = 0; tb < 4; tb++) begin : g_res
        logic signed [PW-1:0] w_sh;
        logic signed [SW-1:0] w_sum;
        always_comb begin
            w_sh  = (r_prod[tb] + (PW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
            w_sum = SW'(r_y0[tb]) + SW'(w_sh);
            if (w_sum > SW'(64'sh7FFF_FFFF)) begin
                w_res[tb] = 32'sh7FFF_FFFF;
            end else if (w_sum < -SW'(64'sh8000_0000)) begin
                w_res[tb] = 32'sh8000_0000;
            end else begin
                w_res[tb] = w_sum[31:0];
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qti_pkg::S_IDLE;
            r_ov    <= 1'b0;
            r_ld_v  <= 1'b0;
            for (int a = 0; a < qti_pkg::AXES; a++) begin
                r_hint[a] <= 3'd0;
            end
        end else begin
            r_state <= n_state;
            r_ld_v  <= (r_state == qti_pkg::S_CR_RD);
            if (r_state == qti_pkg::S_DONE && w_out_free) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
            if (r_state == qti_pkg::S_X0_CK) begin
                r_hint[r_ax] <= r_i;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_ld_m <= r_m;
        case (r_state)
            qti_pkg::S_IDLE: begin
                for (int a = 0; a < qti_pkg::AXES; a++) begin
                    r_qx[a] <= i_item.quad[a];
                end
                r_ax  <= 2'd0;
                r_deg <= 1'b0;
            end
            qti_pkg::S_AX_HI: begin
                r_x <= (r_qx[r_ax] < r_bp_q) ? r_bp_q : r_qx[r_ax];
            end
            qti_pkg::S_AX_CL: begin
                if (r_x > r_bp_q) begin
                    r_x <= r_bp_q;
                end
                r_i <= (r_hint[r_ax] > w_nm2) ? w_nm2 : r_hint[r_ax];
            end
            qti_pkg::S_DN_CK: begin
                if (w_dn_go) begin
                    r_i <= r_i - 3'd1;
                end
            end
            qti_pkg::S_UP_CK: begin
                if (w_up_go) begin
                    r_i <= r_i + 3'd1;
                end else begin
                    r_x1[r_ax] <= r_bp_q;
                end
            end
            qti_pkg::S_X0_CK: begin
                r_x0[r_ax]  <= r_bp_q;
                r_idx[r_ax] <= r_i;
                r_px[r_ax]  <= r_x;
                r_ax        <= 2'(r_ax + 2'd1);
            end
            qti_pkg::S_DV_INIT: begin
                r_dc  <= '0;
                r_quo <= '0;
                r_den <= w_d[31:0];
                if (w_off < 33'sd0) begin
                    r_rem <= '0;
                end else if (w_off > w_d) begin
                    r_rem <= 34'(w_d);
                end else begin
                    r_rem <= 34'(w_off);
                end
                if (!(w_d > 33'sd0)) begin
                    // equal or falling interval: lower value, flagged
                    r_t[r_ax] <= '0;
                    r_deg     <= 1'b1;
                    r_ax      <= 2'(r_ax + 2'd1);
                    r_m       <= 4'd0;
                end
            end
            qti_pkg::S_DV_STEP: begin
                r_quo <= {r_quo[TW-2:0], w_ge};
                r_rem <= (w_ge ? (r_rem - {2'b00, r_den}) : r_rem) << 1;
                r_dc  <= DCW'(r_dc + 1'b1);
                if (r_dc == DCW'(FRAC_BITS)) begin
                    r_t[r_ax] <= {r_quo[TW-2:0], w_ge};
                    r_ax      <= 2'(r_ax + 2'd1);
                    r_m       <= 4'd0;
                end
            end
            qti_pkg::S_CR_RD: begin
                r_m <= r_m + 4'd1;
            end
            qti_pkg::S_CR_END: begin
                r_cnt <= 5'd16;
                r_k   <= 4'd0;
            end
            qti_pkg::S_LP_A: begin
                r_cnt <= r_cnt - 5'd2;
            end
            qti_pkg::S_LP_B: begin
                r_cnt <= r_cnt + 5'd1;
                r_k   <= r_k + 4'd1;
            end
            qti_pkg::S_DONE: begin
                if (w_out_free) begin
                    for (int tb = 0; tb < 4; tb++) begin
                        r_oval[tb] <= r_vals[tb][0];
                    end
                    r_odeg <= r_deg;
                end
            end
            default: begin
                r_ax <= r_ax;
            end
        endcase
    end

    // corner queues: load, pop pairs into the multiplier, push results
    always_ff @(posedge i_clk) begin
        for (int tb = 0; tb < 4; tb++) begin
            if (r_ld_v) begin
                r_vals[tb][r_ld_m] <= r_tab_q[tb*32 +: 32];
            end
            if (r_state == qti_pkg::S_LP_A) begin
                r_y0[tb]   <= r_vals[tb][0];
                r_prod[tb] <= PW'((33'(r_vals[tb][1]) - 33'(r_vals[tb][0]))
                              * $signed({1'b0, r_t[w_lax]}));
                for (int j = 0; j < 14; j++) begin
                    r_vals[tb][j] <= r_vals[tb][j+2];
                end
            end
            if (r_state == qti_pkg::S_LP_B) begin
                r_vals[tb][r_cnt[3:0]] <= w_res[tb];
            end
        end
    end

    assign o_valid        = r_ov;
    assign o_vals         = r_oval;
    assign o_deg          = r_odeg;
    assign o_stat.busy    = (r_state != qti_pkg::S_IDLE);
    assign o_stat.hunting = (r_state == qti_pkg::S_DN_CK) || (r_state == qti_pkg::S_UP_CK);

endmodule

// ----- hdl/quad_table_interpolator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_table_interpolator: four-axis breakpoint table interpolator
//
//   channel   dir   payload
//   s_axis    in    tuser opcode, tdata slot/address/breakpoint/entries/query
//   m_axis    out   tuser degenerate, tdata lift/thrust/moment/inertia
//   apb       in    four 4-bit point count registers at 0x0, 0x4, 0x8, 0xc
//
// The back end takes breakpoint and table writes only while idle. A query runs
// the interval hunt on each axis, the bit-serial divider for each axis weight,
// the read of sixteen corners from the table memory and then the lerp steps
// that reduce them per table.
// Reset is synchronous, active low; it clears hints, queue and output valid.
// A two-word queue lets the input side keep taking words while the back end
// works or while a result waits on m_axis.
// ----------------------------------------------------------------------------
module quad_table_interpolator #(
    parameter int FRAC_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [4:0] breakpoint_slot, [16:5] entry_address, [48:17] breakpoint_value,
    // [80:49] lift_in, [112:81] thrust_in, [144:113] moment_in,
    // [176:145] inertia_in, [208:177] query_alpha, [240:209] query_speed,
    // [272:241] query_freq, [304:273] query_phase, rest zero
    input  logic [qti_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input  logic [1:0]                      s_axis_tuser,   // [1:0] opcode
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [31:0] lift_out, [63:32] thrust_out, [95:64] moment_out,
    // [127:96] inertia_out
    output logic [qti_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    output logic                            m_axis_tuser,   // [0] degenerate
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [3:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    logic [3:0][3:0]    r_pts;
    qti_pkg::t_qitem    w_item;
    logic               w_item_valid;
    logic               w_item_ready;
    qti_pkg::t_fstat    w_fstat;
    qti_pkg::t_bstat    w_bstat;
    logic [3:0][31:0]   w_vals;

    // configuration registers
    assign pready = 1'b1;
    assign prdata = {28'd0, r_pts[paddr[3:2]]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < qti_pkg::AXES; a++) begin
                r_pts[a] <= 4'd2;
            end
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                qti_pkg::REG_ALPHA: r_pts[0] <= pwdata[3:0];
                qti_pkg::REG_SPEED: r_pts[1] <= pwdata[3:0];
                qti_pkg::REG_FREQ:  r_pts[2] <= pwdata[3:0];
                qti_pkg::REG_PHASE: r_pts[3] <= pwdata[3:0];
                default:            r_pts    <= r_pts;
            endcase
        end
    end

    // front: classify and queue
    qti_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_opcode     (s_axis_tuser),
        .i_data       (s_axis_tdata),
        .o_item       (w_item),
        .o_item_valid (w_item_valid),
        .i_item_ready (w_item_ready),
        .o_stat       (w_fstat)
    );

    // back: store, hunt, divide, interpolate
    qti_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (w_item),
        .i_item_valid (w_item_valid),
        .o_item_ready (w_item_ready),
        .i_points     (r_pts),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_vals       (w_vals),
        .o_deg        (m_axis_tuser),
        .o_stat       (w_bstat)
    );

    assign m_axis_tdata = w_vals;

    // checks
    a_rst_clears_out : assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_out_from_work : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_bstat.busy))
        else $error("result word without a query in progress");

    a_queue_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fstat.count <= 2'(qti_pkg::QDEPTH))
        else $error("queue count beyond depth");

    a_hunt_not_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_bstat.hunting |-> !w_item_ready)
        else $error("back end takes words while hunting");

endmodule

// ----- sim/quad_table_interpolator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_table_interpolator_tb: self-checking bench of the table interpolator
// Loads breakpoint axes and coefficient tables over the input stream, sets the
// point counts over apb, runs clamped, hinted queries and checks every result
// word against a predictor kept in step with the accepted words.
// ----------------------------------------------------------------------------
module quad_table_interpolator_tb;

    localparam int WATCH_LIMIT = 20000;

    // result word fields
    typedef struct {
        logic [31:0] lift;
        logic [31:0] thrust;
        logic [31:0] moment;
        logic [31:0] inertia;
        logic        degen;
    } t_coef_result;

    // tracks the block state and the results still owed
    class interp_scoreboard;
        longint      bp_axis [4][8];
        longint      coef [4][4096];
        int unsigned hint [4];
        int unsigned npts [4];
        t_coef_result owed [$];
        int          errors;

        function void reset_state();
            foreach (bp_axis[a, k]) bp_axis[a][k] = 0;
            foreach (coef[t, k]) coef[t][k] = 0;
            for (int a = 0; a < 4; a++) begin
                hint[a] = 0;
                npts[a] = 2;
            end
            owed.delete();
            errors = 0;
        endfunction

        function longint sat(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // weighted blend of one interval, degenerate intervals keep y0
        function longint blend(longint x0, longint y0, longint x1, longint y1,
                               longint x, inout bit deg);
            longint d, off, w, p;
            d = x1 - x0;
            off = x - x0;
            if (d <= 0) begin
                deg = 1;
                return y0;
            end
            if (off < 0) off = 0;
            if (off > d) off = d;
            w = (off <<< 16) / d;
            p = (y1 - y0) * w + (64'sd1 <<< 15);
            return sat(y0 + (p >>> 16));
        endfunction

        function void note_word(logic [1:0] op, logic [4:0] slot, logic [11:0] addr,
                                logic [31:0] bpv, logic [31:0] qd [4]);
            int unsigned idx [4];
            longint      qx [4];
            longint      v [16];
            t_coef_result r;
            bit          deg;
            int unsigned n, i, cnt, ad;
            longint      x, res [4];
            deg = 0;
            if (op == qti_pkg::OP_BPW) begin
                bp_axis[slot[4:3]][slot[2:0]] = longint'(signed'(bpv));
                return;
            end
            if (op == qti_pkg::OP_ENT) begin
                for (int t = 0; t < 4; t++) coef[t][addr] = longint'(signed'(qd[t]));
                return;
            end
            if (op != qti_pkg::OP_QRY) return;
            for (int a = 0; a < 4; a++) begin
                n = npts[a] < 2 ? 2 : (npts[a] > 8 ? 8 : npts[a]);
                i = hint[a];
                x = longint'(signed'(qd[a]));
                if (x < bp_axis[a][0]) x = bp_axis[a][0];
                if (x > bp_axis[a][n-1]) x = bp_axis[a][n-1];
                if (i > n - 2) i = n - 2;
                while (i > 0 && x < bp_axis[a][i]) i--;
                while (i < n - 2 && x > bp_axis[a][i+1]) i++;
                hint[a] = i;
                idx[a] = i;
                qx[a] = x;
            end
            for (int t = 0; t < 4; t++) begin
                for (int m = 0; m < 16; m++) begin
                    ad = ((((idx[0] + m[3]) * 8 + idx[1] + m[2]) * 8 + idx[2] + m[1]) * 8
                          + idx[3] + m[0]) & 12'hfff;
                    v[m] = coef[t][ad];
                end
                cnt = 16;
                for (int a = 3; a >= 0; a--) begin
                    cnt = cnt >> 1;
                    for (int m = 0; m < cnt; m++)
                        v[m] = blend(bp_axis[a][idx[a]], v[2*m], bp_axis[a][idx[a]+1],
                                     v[2*m+1], qx[a], deg);
                end
                res[t] = sat(v[0]);
            end
            r.lift = res[0][31:0];
            r.thrust = res[1][31:0];
            r.moment = res[2][31:0];
            r.inertia = res[3][31:0];
            r.degen = deg;
            owed.push_back(r);
        endfunction

        function void check_word(logic [127:0] data, logic degen);
            t_coef_result e;
            if (owed.size() == 0) begin
                $error("result word with nothing owed: %h", data);
                errors++;
                return;
            end
            e = owed.pop_front();
            if (data[31:0] !== e.lift) begin
                $error("lift_out exp %h got %h", e.lift, data[31:0]); errors++;
            end
            if (data[63:32] !== e.thrust) begin
                $error("thrust_out exp %h got %h", e.thrust, data[63:32]); errors++;
            end
            if (data[95:64] !== e.moment) begin
                $error("moment_out exp %h got %h", e.moment, data[95:64]); errors++;
            end
            if (data[127:96] !== e.inertia) begin
                $error("inertia_out exp %h got %h", e.inertia, data[127:96]); errors++;
            end
            if (degen !== e.degen) begin
                $error("degenerate exp %b got %b", e.degen, degen); errors++;
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic s_axis_tvalid = 0;
    logic s_axis_tready;
    logic [qti_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 0;
    logic [qti_pkg::M_TDATA_W-1:0] m_axis_tdata;
    logic m_axis_tuser;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    interp_scoreboard sb;
    int  idle_cycles = 0;
    bit  no_gaps = 0;
    bit  timed_out = 0;

    always #10 i_clk = ~i_clk;

    quad_table_interpolator DUT (.*);

    // result side: random stall, check at each accepted word
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_word(m_axis_tdata, m_axis_tuser);
    end
    always @(negedge i_clk)
        m_axis_tready <= no_gaps || ($urandom_range(99) >= 12);

    // watchdog on cycles with no word accepted
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCH_LIMIT && !timed_out) begin
            timed_out = 1;
            $display("quad_table_interpolator_tb: errors");
            $finish;
        end
    end

    // valid stays high after a word so the next one can follow at once
    task automatic send_word(logic [1:0] op, logic [4:0] slot, logic [11:0] addr,
                             logic [31:0] bpv, logic [31:0] qd [4]);
        logic [qti_pkg::S_TDATA_W-1:0] w;
        w = '0;
        w[4:0] = slot;
        w[16:5] = addr;
        w[48:17] = bpv;
        for (int k = 0; k < 4; k++) begin
            w[49 + 32*k +: 32] = op == qti_pkg::OP_QRY ? $urandom : qd[k];
            w[177 + 32*k +: 32] = op == qti_pkg::OP_QRY ? qd[k] : $urandom;
        end
        while (!no_gaps && $urandom_range(99) < 12) begin
            s_axis_tvalid <= 0;
            @(negedge i_clk);
        end
        s_axis_tdata <= w;
        s_axis_tuser <= op;
        s_axis_tvalid <= 1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_word(op, slot, addr, bpv, qd);
        @(negedge i_clk);
    endtask

    task automatic write_bp(int a, int k, logic [31:0] v);
        logic [31:0] qd [4];
        qd = '{default: 0};
        send_word(qti_pkg::OP_BPW, 5'(a * 8 + k), 12'($urandom), v, qd);
    endtask

    task automatic write_entry(logic [11:0] ad, logic [31:0] qd [4]);
        send_word(qti_pkg::OP_ENT, 5'($urandom), ad, $urandom, qd);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 0;
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic apb_write(logic [1:0] r, logic [31:0] v);
        psel <= 1; pwrite <= 1; penable <= 0;
        paddr <= {r, 2'b00}; pwdata <= v;
        @(negedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.npts[r] = v[3:0];
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'($urandom_range(65536 * 4)) - 32'd131072;
            default: return $urandom;
        endcase
    endfunction

    // fill every entry a query can reach with the given counts
    task automatic load_tables(int na, int ns, int nf, int np);
        logic [31:0] qd [4];
        for (int a = 0; a < na; a++)
            for (int s = 0; s < ns; s++)
                for (int f = 0; f < nf; f++)
                    for (int p = 0; p < np; p++) begin
                        for (int t = 0; t < 4; t++) qd[t] = rand_coef();
                        write_entry(12'(((a * 8 + s) * 8 + f) * 8 + p), qd);
                    end
    endtask

    // axis mostly ascending, some repeats and some disorder
    task automatic load_axis(int a, int n, int style);
        logic signed [31:0] v;
        v = style == 3 ? 32'sh80000000 : -$signed(32'($urandom_range(400000)));
        for (int k = 0; k < n; k++) begin
            if (style == 1 && k == 1) ;
            else if (style == 2) v = $urandom;
            else if (style == 3) v = k == n - 1 ? 32'sh7fffffff : v + 32'sh10000000;
            else v = v + $signed(32'($urandom_range(300000)) + 1);
            write_bp(a, k, v);
        end
    endtask

    function automatic logic [31:0] rand_query(int a, int n);
        case ($urandom_range(9))
            0: return 32'h80000000;
            1: return 32'h7fffffff;
            2: return $urandom;
            default: return 32'(sb.bp_axis[a][0]) +
                            32'($urandom_range(32'(sb.bp_axis[a][n-1] - sb.bp_axis[a][0])));
        endcase
    endfunction

    task automatic run_phase(int counts [4], int styles [4], int nq);
        logic [31:0] qd [4];
        for (int a = 0; a < 4; a++) apb_write(2'(a), 32'(counts[a]));
        for (int a = 0; a < 4; a++) load_axis(a, counts[a] < 2 ? 2 :
                                               (counts[a] > 8 ? 8 : counts[a]), styles[a]);
        load_tables(sb.npts[0] < 2 ? 2 : (sb.npts[0] > 8 ? 8 : sb.npts[0]),
                    sb.npts[1] < 2 ? 2 : (sb.npts[1] > 8 ? 8 : sb.npts[1]),
                    sb.npts[2] < 2 ? 2 : (sb.npts[2] > 8 ? 8 : sb.npts[2]),
                    sb.npts[3] < 2 ? 2 : (sb.npts[3] > 8 ? 8 : sb.npts[3]));
        for (int k = 0; k < nq; k++) begin
            for (int a = 0; a < 4; a++)
                qd[a] = rand_query(a, sb.npts[a] < 2 ? 2 :
                                      (sb.npts[a] > 8 ? 8 : sb.npts[a]));
            // unused opcode now and then, ignored by the block
            if ($urandom_range(30) == 0)
                send_word(qti_pkg::OP_UNUSED, 5'($urandom), 12'($urandom), $urandom, qd);
            send_word(qti_pkg::OP_QRY, 5'($urandom), 12'($urandom), $urandom, qd);
        end
        wait_drained();
    endtask

    initial begin
        int counts [4];
        int styles [4];
        logic [31:0] qd [4];
        sb = new();
        sb.reset_state();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: reset counts, full range axes, extreme tables and queries
        for (int a = 0; a < 4; a++) begin
            write_bp(a, 0, 32'h80000000);
            write_bp(a, 1, 32'h7fffffff);
        end
        for (int m = 0; m < 16; m++) begin
            for (int t = 0; t < 4; t++) qd[t] = m[t] ? 32'h7fffffff : 32'h80000000;
            write_entry(12'(((m[3] * 8 + m[2]) * 8 + m[1]) * 8 + m[0]), qd);
        end
        qd = '{32'h80000000, 32'h7fffffff, 32'h0, 32'h1};
        send_word(qti_pkg::OP_QRY, '1, '1, '1, qd);
        qd = '{32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h0};
        send_word(qti_pkg::OP_QRY, '0, '0, '0, qd);
        send_word(qti_pkg::OP_UNUSED, '1, '1, '1, qd);
        // equal breakpoints give a degenerate interval
        write_bp(2, 1, 32'h80000000);
        send_word(qti_pkg::OP_QRY, '0, '0, '0, qd);
        wait_drained();

        // counts out of range, the extremes, then random settings
        counts = '{0, 15, 8, 1};
        styles = '{0, 1, 3, 0};
        run_phase(counts, styles, 30);
        counts = '{8, 8, 2, 2};
        styles = '{0, 0, 2, 1};
        run_phase(counts, styles, 40);
        no_gaps = 1;
        counts = '{2, 3, 2, 4};
        styles = '{0, 0, 0, 0};
        run_phase(counts, styles, 60);
        no_gaps = 0;
        for (int ph = 0; ph < 4; ph++) begin
            for (int a = 0; a < 4; a++) begin
                counts[a] = $urandom_range(10) == 0 ? $urandom_range(15) : $urandom_range(2, 4);
                styles[a] = $urandom_range(9) < 7 ? 0 : $urandom_range(1, 3);
            end
            run_phase(counts, styles, 70);
        end

        if (sb.errors == 0)
            $display("quad_table_interpolator_tb: clean");
        else
            $display("quad_table_interpolator_tb: errors");
        $finish;
    end
endmodule
